[sv/lpz_pkg.sv]
// Shared types and constants for the lidar packet zero-suppress encoder.
// No dependencies.

package lpz_pkg;

  localparam int BEAT_BYTES  = 32;
  localparam int CHUNK_BYTES = 8;
  localparam int BEAT_BITS   = BEAT_BYTES * 8;
  localparam int CNT_W       = 6;
  localparam int OUT_W       = 264;
  localparam int MASK_W      = 64;
  localparam int IN_W        = 64;

  localparam logic [3:0] HDR_BYTES  = 4'd5;
  localparam logic [3:0] ROT_BYTES  = 4'd2;
  localparam logic [3:0] MASK_BYTES = 4'(64 / 8);
  localparam logic [3:0] RNG_BYTES  = 4'd2;
  localparam logic [7:0] PAIR_NONE  = 8'h00;

  typedef struct packed {
    logic                     vld;
    logic                     last;
    logic [3:0]               nbytes;
    logic [CHUNK_BYTES*8-1:0] data;
  } lpz_push_t;

endpackage

[sv/lpz_range_mem.sv]
// Range store: single write port, single read port, registered read data.
// No dependencies.

module lpz_range_mem #(
  parameter int DEPTH = 384,
  parameter int AW    = 9
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [15:0]   wdata,
  input  logic [AW-1:0] raddr,
  output logic [15:0]   rdata
);

  logic [15:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[sv/lpz_packer.sv]
// Byte packer: merges variable-size byte chunks into 32-byte output beats.
// Depends on lpz_pkg.

module lpz_packer import lpz_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  lpz_push_t        push,
  output logic             push_rdy,
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [OUT_W-1:0] out_tdata,
  output logic             out_tlast
);

  localparam int MRG_BITS = (BEAT_BYTES + CHUNK_BYTES) * 8;

  logic [BEAT_BITS-1:0] acc_r, acc_nxt;
  logic [CNT_W-1:0]     fill_r, fill_nxt;
  logic [BEAT_BITS-1:0] beat_r, beat_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic                 last_r, last_nxt;
  logic                 vld_r, vld_nxt;

  logic [MRG_BITS-1:0]  merged;
  logic [CNT_W:0]       total;
  logic                 take;

  assign push_rdy = !vld_r || out_tready;
  assign take     = push.vld && push_rdy;

  always_comb begin
    merged = '0;
    for (int j = 0; j < BEAT_BYTES; j++) begin
      if (j < int'(fill_r)) begin
        merged[j*8 +: 8] = acc_r[j*8 +: 8];
      end
    end
    for (int j = 0; j < CHUNK_BYTES; j++) begin
      if (j < int'(push.nbytes)) begin
        merged[(int'(fill_r) + j)*8 +: 8] = push.data[j*8 +: 8];
      end
    end
    total = (CNT_W+1)'(fill_r) + (CNT_W+1)'(push.nbytes);

    acc_nxt  = acc_r;
    fill_nxt = fill_r;
    beat_nxt = beat_r;
    cnt_nxt  = cnt_r;
    last_nxt = last_r;
    vld_nxt  = vld_r;
    if (vld_r && out_tready) begin
      vld_nxt = 1'b0;
    end
    if (take) begin
      if (push.last || total > (CNT_W+1)'(BEAT_BYTES)) begin
        beat_nxt = merged[BEAT_BITS-1:0];
        cnt_nxt  = push.last ? CNT_W'(total) : CNT_W'(BEAT_BYTES);
        last_nxt = push.last;
        vld_nxt  = 1'b1;
        acc_nxt  = '0;
        acc_nxt[CHUNK_BYTES*8-1:0] = merged[MRG_BITS-1:BEAT_BITS];
        fill_nxt = push.last ? '0 : CNT_W'(total - (CNT_W+1)'(BEAT_BYTES));
      end else begin
        acc_nxt  = merged[BEAT_BITS-1:0];
        fill_nxt = CNT_W'(total);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= 1'b0;
      fill_r <= '0;
    end else begin
      vld_r  <= vld_nxt;
      fill_r <= fill_nxt;
    end
    acc_r  <= acc_nxt;
    beat_r <= beat_nxt;
    cnt_r  <= cnt_nxt;
    last_r <= last_nxt;
  end

  assign out_tvalid = vld_r;
  assign out_tlast  = last_r;
  assign out_tdata  = {{(OUT_W - BEAT_BITS - CNT_W){1'b0}}, cnt_r, beat_r};

endmodule

[sv/lidar_packet_zero_suppress_encoder.sv]
// Top level of the lidar packet zero-suppress encoder.
// Depends on lpz_pkg, lpz_range_mem and lpz_packer.
//
// Usage:
//   in_* channel: one laser return per transfer. A packet is PAIRS block pairs,
//   each LASERS upper then LASERS lower returns, 2*PAIRS*LASERS transfers.
//   out_* channel: the compacted byte stream of the packet, 32 bytes a beat,
//   byte count in tdata, tlast on the final beat.
//   Throughput: returns are taken one per cycle while collecting. After the
//   last return in_tready stays low while the stream drains: a header step,
//   a skip step per absent pair, and per present pair a rotation step, a mask
//   step and one range memory read per return of the pair on its single read
//   port, then an end-of-pairs step and a flush step; pushes wait on stalls.
//   Latency: a beat is presented the cycle after a chunk overflows it or the
//   stream ends; the first beat may trail the last return by up to the drain.
//   Reset: synchronous; clears counters, masks and the output register. The
//   range memory and rotation rows are not cleared.
//   Stall: a held output beat stops the drain at the next chunk; the next
//   packet may be collected while the final beat waits.

module lidar_packet_zero_suppress_encoder import lpz_pkg::*; #(
  parameter int PAIRS  = 6,
  parameter int LASERS = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [IN_W-1:0]  in_tdata,   // scan_number[31:0], rotation[47:32], range[63:48]
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [OUT_W-1:0] out_tdata,  // word0..word3[255:0], byte_count[261:256], pad
  output logic             out_tlast
);

  localparam int PER_PAIR = 2 * LASERS;
  localparam int TOTAL    = PAIRS * PER_PAIR;
  localparam int AW       = $clog2(TOTAL);
  localparam int KW       = $clog2(PER_PAIR);
  localparam int PW       = (PAIRS > 1) ? $clog2(PAIRS) : 1;
  localparam int PCW      = $clog2(PAIRS + 1);

  typedef enum logic [2:0] {
    S_COLLECT,
    S_HDR,
    S_PAIR,
    S_MASK,
    S_RANGE,
    S_FLUSH
  } state_t;

  state_t             state_r, state_nxt;
  logic [PW-1:0]      cap_p_r, cap_p_nxt;
  logic [KW-1:0]      cap_k_r, cap_k_nxt;
  logic [AW-1:0]      cap_addr_r, cap_addr_nxt;
  logic [31:0]        held_scan_r, held_scan_nxt;
  logic [7:0]         pair_mask_r, pair_mask_nxt;
  logic [MASK_W-1:0]  lmask_r [PAIRS];
  logic [MASK_W-1:0]  lmask_nxt [PAIRS];
  logic [15:0]        rot_r [PAIRS];
  logic [PCW-1:0]     p_r, p_nxt;
  logic [KW-1:0]      k_r, k_nxt;
  logic [AW-1:0]      rd_addr_r, rd_addr_nxt;

  logic [31:0]        in_scan;
  logic [15:0]        in_rot;
  logic [15:0]        in_rng;
  logic               cap_fire;
  logic [15:0]        rdata;
  logic [PW-1:0]      p_idx;
  logic               cur_bit;
  lpz_push_t          push;
  logic               push_rdy;

  assign in_scan   = in_tdata[31:0];
  assign in_rot    = in_tdata[47:32];
  assign in_rng    = in_tdata[63:48];
  assign in_tready = (state_r == S_COLLECT);
  assign cap_fire  = in_tvalid && in_tready;
  assign p_idx     = p_r[PW-1:0];
  assign cur_bit   = lmask_r[p_idx][6'(k_r)];

  lpz_range_mem #(
    .DEPTH (TOTAL),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (cap_fire),
    .waddr (cap_addr_r),
    .wdata (in_rng),
    .raddr (rd_addr_nxt),
    .rdata (rdata)
  );

  lpz_packer u_pack (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_rdy   (push_rdy),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always_comb begin
    state_nxt     = state_r;
    cap_p_nxt     = cap_p_r;
    cap_k_nxt     = cap_k_r;
    cap_addr_nxt  = cap_addr_r;
    held_scan_nxt = held_scan_r;
    pair_mask_nxt = pair_mask_r;
    lmask_nxt     = lmask_r;
    p_nxt         = p_r;
    k_nxt         = k_r;
    rd_addr_nxt   = rd_addr_r;
    push          = '0;

    case (state_r)
      S_COLLECT: begin
        if (cap_fire) begin
          if (cap_addr_r == '0) begin
            held_scan_nxt = in_scan;
          end
          if (in_rng != 16'd0) begin
            lmask_nxt[cap_p_r][6'(cap_k_r)] = 1'b1;
            pair_mask_nxt[3'(cap_p_r)]      = 1'b1;
          end
          if (cap_k_r == KW'(PER_PAIR - 1)) begin
            cap_k_nxt = '0;
            if (cap_p_r == PW'(PAIRS - 1)) begin
              cap_p_nxt    = '0;
              cap_addr_nxt = '0;
              state_nxt    = S_HDR;
            end else begin
              cap_p_nxt    = cap_p_r + 1'b1;
              cap_addr_nxt = cap_addr_r + 1'b1;
            end
          end else begin
            cap_k_nxt    = cap_k_r + 1'b1;
            cap_addr_nxt = cap_addr_r + 1'b1;
          end
        end
      end
      S_HDR: begin
        push.vld    = 1'b1;
        push.nbytes = HDR_BYTES;
        push.data   = {24'd0, pair_mask_r, held_scan_r};
        if (push_rdy) begin
          p_nxt     = '0;
          state_nxt = S_PAIR;
        end
      end
      S_PAIR: begin
        if (p_r == PCW'(PAIRS)) begin
          state_nxt = S_FLUSH;
        end else if (pair_mask_r[3'(p_idx)]) begin
          push.vld    = 1'b1;
          push.nbytes = ROT_BYTES;
          push.data   = {48'd0, rot_r[p_idx]};
          if (push_rdy) begin
            state_nxt = S_MASK;
          end
        end else begin
          p_nxt = p_r + 1'b1;
        end
      end
      S_MASK: begin
        push.vld    = 1'b1;
        push.nbytes = MASK_BYTES;
        push.data   = lmask_r[p_idx];
        if (push_rdy) begin
          k_nxt       = '0;
          rd_addr_nxt = AW'(int'(p_idx) * PER_PAIR);
          state_nxt   = S_RANGE;
        end
      end
      S_RANGE: begin
        if (cur_bit) begin
          push.vld    = 1'b1;
          push.nbytes = RNG_BYTES;
          push.data   = {48'd0, rdata};
        end
        if (!cur_bit || push_rdy) begin
          if (k_r == KW'(PER_PAIR - 1)) begin
            p_nxt     = p_r + 1'b1;
            state_nxt = S_PAIR;
          end else begin
            k_nxt       = k_r + 1'b1;
            rd_addr_nxt = rd_addr_r + 1'b1;
          end
        end
      end
      S_FLUSH: begin
        push.vld  = 1'b1;
        push.last = 1'b1;
        if (push_rdy) begin
          pair_mask_nxt = PAIR_NONE;
          for (int i = 0; i < PAIRS; i++) begin
            lmask_nxt[i] = '0;
          end
          state_nxt = S_COLLECT;
        end
      end
      default: begin
        state_nxt = S_COLLECT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_COLLECT;
      cap_p_r     <= '0;
      cap_k_r     <= '0;
      cap_addr_r  <= '0;
      held_scan_r <= '0;
      pair_mask_r <= PAIR_NONE;
      for (int i = 0; i < PAIRS; i++) begin
        lmask_r[i] <= '0;
      end
      p_r         <= '0;
      k_r         <= '0;
      rd_addr_r   <= '0;
    end else begin
      state_r     <= state_nxt;
      cap_p_r     <= cap_p_nxt;
      cap_k_r     <= cap_k_nxt;
      cap_addr_r  <= cap_addr_nxt;
      held_scan_r <= held_scan_nxt;
      pair_mask_r <= pair_mask_nxt;
      lmask_r     <= lmask_nxt;
      p_r         <= p_nxt;
      k_r         <= k_nxt;
      rd_addr_r   <= rd_addr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cap_fire && cap_k_r == '0) begin
      rot_r[cap_p_r] <= in_rot;
    end
  end

endmodule

[sv/lpz_checker.sv]
// Port-level checks for the lidar packet zero-suppress encoder, bound to the top.
// Depends on lpz_pkg and lidar_packet_zero_suppress_encoder.

module lpz_checker import lpz_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             in_tready,
  input logic             out_tvalid,
  input logic             out_tready,
  input logic [OUT_W-1:0] out_tdata,
  input logic             out_tlast
);

  a_reset_state: assert property (@(posedge clk)
    !rst_n |=> in_tready && !out_tvalid)
    else $error("collect not ready or output valid after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled beat changed");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[BEAT_BITS +: CNT_W] != 6'd0) &&
                   (out_tdata[BEAT_BITS +: CNT_W] <= 6'(BEAT_BYTES)))
    else $error("byte count out of range");

  a_full_inner: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> out_tdata[BEAT_BITS +: CNT_W] == 6'(BEAT_BYTES))
    else $error("short beat before end of stream");

endmodule

bind lidar_packet_zero_suppress_encoder lpz_checker u_lpz_checker (.*);
